// ===== hdl/ground_to_image_projection_assert.svh =====
`ifndef GROUND_TO_IMAGE_PROJECTION_ASSERT_SVH
`define GROUND_TO_IMAGE_PROJECTION_ASSERT_SVH

// Implication checked while out of reset.
`define GIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, also checked across reset.
`define GIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gip_pkg.sv =====
package gip_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PROD_W = 2 * WORD_WIDTH;
  localparam int SUM_W  = 2 * WORD_WIDTH + 2;
  localparam int MAG_W  = 2 * WORD_WIDTH + 1;
  // Working width of the divider: numerator shifted by FRAC_BITS, divisor by WORD_WIDTH.
  localparam int DIV_W  = MAG_W + WORD_WIDTH + FRAC_BITS;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic        [WORD_WIDTH-1:0] uword_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic        [MAG_W-1:0]      mag_t;
  typedef logic        [DIV_W-1:0]      dword_t;

  localparam logic [31:0] OUT_MAX = 32'((64'd1 << (WORD_WIDTH - 1)) - 64'd1);
  localparam logic [31:0] OUT_MIN = ~OUT_MAX;

  typedef enum logic [2:0] {
    CFG_ROW0       = 3'd0,
    CFG_ROW1       = 3'd1,
    CFG_ROW2       = 3'd2,
    CFG_COL2_TOP   = 3'd3,
    CFG_LAST_HGT   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    word_t m00, m01, m02;
    word_t m10, m11, m12;
    word_t m20, m21, m22;
    word_t hgt;
  } gip_coef_t;

  // Control that travels with each item through the divider.
  typedef struct packed {
    logic valid;
    logic zero;
    logic neg_u;
    logic neg_v;
  } gip_ctl_t;

endpackage

// ===== hdl/ground_to_image_projection.sv =====
// An item passes the product, sum, sign/magnitude, divider stage and output registers.
// Throughput: one item per cycle while not stalled; the divider is fully pipelined, one
// quotient bit a stage. A stalled output freezes the whole pipeline, so nothing is
// dropped or repeated. Reset (synchronous, rst_n low) empties the pipeline and loads the
// identity element (2,2) = 1.0 with all other coefficients and the ground height at zero.
module ground_to_image_projection import gip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_ground_x,
  input  logic signed [31:0] in_ground_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_image_u,
  output logic signed [31:0] out_image_v,
  output logic [1:0]  out_status
);

`include "ground_to_image_projection_assert.svh"

  logic [63:0] row0_r, row1_r, row2_r, col2_r, last_r;
  gip_coef_t   coef;
  logic        en;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= '0;
      row1_r <= '0;
      row2_r <= '0;
      col2_r <= '0;
      last_r <= 64'd1 << (32 + FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW0:     row0_r <= cfg_data;
        CFG_ROW1:     row1_r <= cfg_data;
        CFG_ROW2:     row2_r <= cfg_data;
        CFG_COL2_TOP: col2_r <= cfg_data;
        CFG_LAST_HGT: last_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef.m00 = word_t'(row0_r[32 +: WORD_WIDTH]);
  assign coef.m01 = word_t'(row0_r[0 +: WORD_WIDTH]);
  assign coef.m10 = word_t'(row1_r[32 +: WORD_WIDTH]);
  assign coef.m11 = word_t'(row1_r[0 +: WORD_WIDTH]);
  assign coef.m20 = word_t'(row2_r[32 +: WORD_WIDTH]);
  assign coef.m21 = word_t'(row2_r[0 +: WORD_WIDTH]);
  assign coef.m02 = word_t'(col2_r[32 +: WORD_WIDTH]);
  assign coef.m12 = word_t'(col2_r[0 +: WORD_WIDTH]);
  assign coef.m22 = word_t'(last_r[32 +: WORD_WIDTH]);
  assign coef.hgt = word_t'(last_r[0 +: WORD_WIDTH]);

  assign in_stall = out_valid_r && out_stall;
  assign en       = !in_stall;

  logic sum_valid;
  sum_t sum0, sum1, sum2;

  gip_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .x         (word_t'(in_ground_x[WORD_WIDTH-1:0])),
    .y         (word_t'(in_ground_y[WORD_WIDTH-1:0])),
    .coef      (coef),
    .sum_valid (sum_valid),
    .sum0      (sum0),
    .sum1      (sum1),
    .sum2      (sum2)
  );

  // Sign and magnitude of each row sum.
  gip_ctl_t ctl_r, ctl_nxt;
  mag_t     mu_r, mv_r, md_r;
  logic     su, sv, sd;
  mag_t     mu_nxt, mv_nxt, md_nxt;

  assign su     = sum0[SUM_W-1];
  assign sv     = sum1[SUM_W-1];
  assign sd     = sum2[SUM_W-1];
  assign mu_nxt = su ? MAG_W'(-sum0) : MAG_W'(sum0);
  assign mv_nxt = sv ? MAG_W'(-sum1) : MAG_W'(sum1);
  assign md_nxt = sd ? MAG_W'(-sum2) : MAG_W'(sum2);

  always_comb begin
    ctl_nxt.valid = sum_valid;
    ctl_nxt.zero  = sum2 == '0;
    ctl_nxt.neg_u = (su != sd) && (sum0 != '0);
    ctl_nxt.neg_v = (sv != sd) && (sum1 != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_r <= mu_nxt;
      mv_r <= mv_nxt;
      md_r <= md_nxt;
    end
  end

  gip_ctl_t dctl;
  logic     ovf_u, ovf_v;
  uword_t   q_u, q_v;

  gip_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ctl_r),
    .num_u (mu_r),
    .num_v (mv_r),
    .den   (md_r),
    .ctl_o (dctl),
    .ovf_u (ovf_u),
    .ovf_v (ovf_v),
    .q_u   (q_u),
    .q_v   (q_v)
  );

  // Saturation limit is 2^(W-1) for a negative result and one less otherwise.
  uword_t lim_u, lim_v, val_u, val_v;
  word_t  res_u, res_v;
  logic   sat_u, sat_v;
  logic signed [31:0] u_nxt, v_nxt;
  status_t st_nxt;

  assign lim_u = {1'b0, {(WORD_WIDTH-1){1'b1}}} + uword_t'(dctl.neg_u);
  assign lim_v = {1'b0, {(WORD_WIDTH-1){1'b1}}} + uword_t'(dctl.neg_v);
  assign sat_u = ovf_u || (q_u > lim_u);
  assign sat_v = ovf_v || (q_v > lim_v);
  assign val_u = sat_u ? lim_u : q_u;
  assign val_v = sat_v ? lim_v : q_v;
  assign res_u = dctl.neg_u ? word_t'(-val_u) : word_t'(val_u);
  assign res_v = dctl.neg_v ? word_t'(-val_v) : word_t'(val_v);

  always_comb begin
    if (dctl.zero) begin
      u_nxt  = '0;
      v_nxt  = '0;
      st_nxt = ST_ZERO;
    end else begin
      u_nxt  = 32'(res_u);
      v_nxt  = 32'(res_v);
      st_nxt = (sat_u || sat_v) ? ST_SAT : ST_OK;
    end
  end

  logic signed [31:0] u_r, v_r;
  status_t            st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= u_nxt;
      v_r  <= v_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_image_u = u_r;
  assign out_image_v = v_r;
  assign out_status  = st_r;

  `GIP_ASSERT_IMP(a_zero_out, out_valid && out_status == ST_ZERO, out_image_u == '0 && out_image_v == '0, "zero divisor must give zero coordinates")
  `GIP_ASSERT_IMP(a_sat_lim, out_valid && out_status == ST_SAT, out_image_u == OUT_MAX || out_image_u == OUT_MIN || out_image_v == OUT_MAX || out_image_v == OUT_MIN, "saturated item without a coordinate at a limit")
  `GIP_ASSERT_NXT(a_rst_empty, !rst_n, !out_valid, "pipeline not empty after reset")

endmodule

// ===== hdl/gip_mac.sv =====
module gip_mac import gip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  word_t     x,
  input  word_t     y,
  input  gip_coef_t coef,
  output logic      sum_valid,
  output sum_t      sum0,
  output sum_t      sum1,
  output sum_t      sum2
);

  logic  prod_valid_r, sum_valid_r;
  prod_t prod_r [9];
  sum_t  sum_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else if (en) begin
      prod_valid_r <= in_valid;
      sum_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= coef.m00 * x;
      prod_r[1] <= coef.m01 * y;
      prod_r[2] <= coef.m02 * coef.hgt;
      prod_r[3] <= coef.m10 * x;
      prod_r[4] <= coef.m11 * y;
      prod_r[5] <= coef.m12 * coef.hgt;
      prod_r[6] <= coef.m20 * x;
      prod_r[7] <= coef.m21 * y;
      prod_r[8] <= coef.m22 * coef.hgt;
      sum_r[0]  <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
      sum_r[1]  <= SUM_W'(prod_r[3]) + SUM_W'(prod_r[4]) + SUM_W'(prod_r[5]);
      sum_r[2]  <= SUM_W'(prod_r[6]) + SUM_W'(prod_r[7]) + SUM_W'(prod_r[8]);
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum0      = sum_r[0];
  assign sum1      = sum_r[1];
  assign sum2      = sum_r[2];

endmodule

// ===== hdl/gip_div.sv =====
module gip_div import gip_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  gip_ctl_t ctl_i,
  input  mag_t     num_u,
  input  mag_t     num_v,
  input  mag_t     den,
  output gip_ctl_t ctl_o,
  output logic     ovf_u,
  output logic     ovf_v,
  output uword_t   q_u,
  output uword_t   q_v
);

  gip_ctl_t ctl_r  [WORD_WIDTH+1];
  dword_t   ru_r   [WORD_WIDTH+1];
  dword_t   rv_r   [WORD_WIDTH+1];
  mag_t     d_r    [WORD_WIDTH+1];
  logic     ovfu_r [WORD_WIDTH+1];
  logic     ovfv_r [WORD_WIDTH+1];
  uword_t   qu_r   [WORD_WIDTH+1];
  uword_t   qv_r   [WORD_WIDTH+1];

  dword_t nu_ext, nv_ext, d_top;

  assign nu_ext = DIV_W'(num_u) << FRAC_BITS;
  assign nv_ext = DIV_W'(num_v) << FRAC_BITS;
  assign d_top  = DIV_W'(den) << WORD_WIDTH;

  // First stage: a quotient of 2^WORD_WIDTH or more cannot be represented.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ru_r[0]   <= nu_ext;
      rv_r[0]   <= nv_ext;
      d_r[0]    <= den;
      ovfu_r[0] <= nu_ext >= d_top;
      ovfv_r[0] <= nv_ext >= d_top;
      qu_r[0]   <= '0;
      qv_r[0]   <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < WORD_WIDTH; k++) begin : g_stg
    localparam int SH = WORD_WIDTH - 1 - k;
    dword_t dsh;
    logic   ge_u, ge_v;

    assign dsh  = DIV_W'(d_r[k]) << SH;
    assign ge_u = ru_r[k] >= dsh;
    assign ge_v = rv_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ru_r[k+1]   <= ge_u ? ru_r[k] - dsh : ru_r[k];
        rv_r[k+1]   <= ge_v ? rv_r[k] - dsh : rv_r[k];
        d_r[k+1]    <= d_r[k];
        ovfu_r[k+1] <= ovfu_r[k];
        ovfv_r[k+1] <= ovfv_r[k];
        qu_r[k+1]   <= {qu_r[k][WORD_WIDTH-2:0], ge_u};
        qv_r[k+1]   <= {qv_r[k][WORD_WIDTH-2:0], ge_v};
      end
    end
  end

  assign ctl_o = ctl_r[WORD_WIDTH];
  assign ovf_u = ovfu_r[WORD_WIDTH];
  assign ovf_v = ovfv_r[WORD_WIDTH];
  assign q_u   = qu_r[WORD_WIDTH];
  assign q_v   = qv_r[WORD_WIDTH];

endmodule
